// File: rtl/sql_window_aggregate_engine_assert.svh
// Assertion macros for the window aggregate engine
`ifndef SQL_WINDOW_AGGREGATE_ENGINE_ASSERT_SVH
`define SQL_WINDOW_AGGREGATE_ENGINE_ASSERT_SVH
`define SWA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and codes of the window aggregate engine.
// ----------------------------------------------------------------------------
package swa_pkg;
    localparam logic [2:0] KIND_ROW_NUMBER = 3'd0;
    localparam logic [2:0] KIND_RANK       = 3'd1;
    localparam logic [2:0] KIND_DENSE_RANK = 3'd2;
    localparam logic [2:0] KIND_COUNT      = 3'd3;
    localparam logic [2:0] KIND_MIN        = 3'd4;
    localparam logic [2:0] KIND_MAX        = 3'd5;
    localparam logic [2:0] KIND_SUM        = 3'd6;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_SAT      = 2'd2;

    localparam logic CFG_AGG_KIND   = 1'b0;
    localparam logic CFG_COUNT_STAR = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch input row
        logic emit;        // emit current entry
        logic end_group;   // finish the group bookkeeping
        logic part_clear;  // clear partition state
        logic take;        // fold the held row in
        logic stream_clear;
    } swa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_flush;  // have_row and key change
        logic part_change;
        logic last;        // held row closes the stream
        logic emit_last;   // the entry being emitted is the last in buffer
    } swa_sts_t;
endpackage

// File: rtl/swa_datapath.sv
// ----------------------------------------------------------------------------
// swa_datapath
// Row registers, tag buffer, accumulator and rank counters.
// ----------------------------------------------------------------------------
module swa_datapath #(
    parameter int GROUP_DEPTH = 32,
    parameter int TAG_BITS    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           agg_kind,
    input  logic                 count_star,
    input  logic [63:0]          s_partition_key,
    input  logic [63:0]          s_order_key,
    input  logic signed [63:0]   s_arg_value,
    input  logic                 s_arg_is_null,
    input  logic [15:0]          s_row_tag,
    input  logic                 s_stream_end,
    input  swa_pkg::swa_cmd_t    cmd,
    output swa_pkg::swa_sts_t    sts,
    output logic [15:0]          res_tag,
    output logic signed [63:0]   res_value,
    output logic                 res_null,
    output logic [1:0]           res_err
);
    localparam int CW = $clog2(GROUP_DEPTH + 1);
    localparam int AW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    logic [TAG_BITS-1:0] tags_mem [GROUP_DEPTH];
    logic [TAG_BITS-1:0] rd_tag_reg;
    logic [63:0] pkey_reg, okey_reg, val_reg;
    logic        null_reg, eoi_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [63:0] prev_pkey_reg, prev_okey_reg;
    logic        have_row_reg;
    logic [CW-1:0] count_reg, rd_idx_reg;
    logic        ovf_reg;
    logic [63:0] size_reg, acc_reg, rank_reg, rownum_reg;
    logic        empty_reg, sat_reg;
    logic [63:0] sum;
    logic        sum_ovf;

    assign sum     = acc_reg + val_reg;
    assign sum_ovf = (((acc_reg ^ val_reg) & SIGN64) == 64'd0)
                     && (((sum ^ acc_reg) & SIGN64) != 64'd0);

    assign sts.need_flush  = have_row_reg && (pkey_reg != prev_pkey_reg
                                              || okey_reg != prev_okey_reg);
    assign sts.part_change = pkey_reg != prev_pkey_reg;
    assign sts.last        = eoi_reg;
    assign sts.emit_last   = (rd_idx_reg + CW'(1)) == count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pkey_reg <= s_partition_key;
            okey_reg <= s_order_key;
            val_reg  <= s_arg_value;
            null_reg <= s_arg_is_null;
            tag_reg  <= TAG_BITS'(s_row_tag);
            eoi_reg  <= s_stream_end;
        end
        if (cmd.take && count_reg < CW'(GROUP_DEPTH)) begin
            tags_mem[count_reg[AW-1:0]] <= tag_reg;
        end
        rd_tag_reg <= tags_mem[rd_idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.stream_clear) begin
            prev_pkey_reg <= '0;
            prev_okey_reg <= '0;
            have_row_reg  <= 1'b0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            ovf_reg       <= 1'b0;
            size_reg      <= '0;
            acc_reg       <= '0;
            empty_reg     <= 1'b1;
            sat_reg       <= 1'b0;
            rank_reg      <= 64'd1;
            rownum_reg    <= 64'd1;
        end else begin
            if (cmd.emit) begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
                if (agg_kind == swa_pkg::KIND_ROW_NUMBER) rownum_reg <= rownum_reg + 64'd1;
            end
            if (cmd.end_group) begin
                if (agg_kind == swa_pkg::KIND_ROW_NUMBER)
                    rownum_reg <= rownum_reg + 64'd1 + size_reg - 64'(count_reg);
                else
                    rownum_reg <= rownum_reg + size_reg;
                if (agg_kind == swa_pkg::KIND_DENSE_RANK) rank_reg <= rank_reg + 64'd1;
                else rank_reg <= rank_reg + size_reg;
                count_reg  <= '0;
                rd_idx_reg <= '0;
                ovf_reg    <= 1'b0;
                size_reg   <= '0;
            end
            if (cmd.part_clear) begin
                acc_reg    <= '0;
                empty_reg  <= 1'b1;
                sat_reg    <= 1'b0;
                rank_reg   <= 64'd1;
                rownum_reg <= 64'd1;
            end
            if (cmd.take) begin
                if (count_reg < CW'(GROUP_DEPTH)) count_reg <= count_reg + CW'(1);
                else ovf_reg <= 1'b1;
                size_reg      <= size_reg + 64'd1;
                prev_pkey_reg <= pkey_reg;
                prev_okey_reg <= okey_reg;
                have_row_reg  <= 1'b1;
                case (agg_kind)
                    swa_pkg::KIND_COUNT: begin
                        if (count_star || !null_reg) acc_reg <= acc_reg + 64'd1;
                    end
                    swa_pkg::KIND_MIN, swa_pkg::KIND_MAX, swa_pkg::KIND_SUM: begin
                        if (!null_reg) begin
                            empty_reg <= 1'b0;
                            if (empty_reg) acc_reg <= val_reg;
                            else if (agg_kind == swa_pkg::KIND_MIN) begin
                                if ($signed(val_reg) < $signed(acc_reg)) acc_reg <= val_reg;
                            end else if (agg_kind == swa_pkg::KIND_MAX) begin
                                if ($signed(acc_reg) < $signed(val_reg)) acc_reg <= val_reg;
                            end else if (sum_ovf) begin
                                sat_reg <= 1'b1;
                                acc_reg <= acc_reg[63] ? SIGN64 : ~SIGN64;
                            end else begin
                                acc_reg <= sum;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        res_tag   = 16'(rd_tag_reg);
        res_value = '0;
        res_null  = 1'b0;
        case (agg_kind)
            swa_pkg::KIND_ROW_NUMBER: res_value = rownum_reg;
            swa_pkg::KIND_RANK, swa_pkg::KIND_DENSE_RANK: res_value = rank_reg;
            swa_pkg::KIND_COUNT: res_value = acc_reg;
            swa_pkg::KIND_MIN, swa_pkg::KIND_MAX, swa_pkg::KIND_SUM: begin
                if (empty_reg) res_null = 1'b1;
                else res_value = acc_reg;
            end
            default: res_null = 1'b1;
        endcase
        if (ovf_reg) res_err = swa_pkg::ERR_OVERFLOW;
        else if (agg_kind == swa_pkg::KIND_SUM && sat_reg) res_err = swa_pkg::ERR_SAT;
        else res_err = swa_pkg::ERR_OK;
    end
endmodule

// File: rtl/swa_ctrl.sv
// ----------------------------------------------------------------------------
// swa_ctrl
// Sequencer: accept a row, flush the finished group, fold the row in.
// ----------------------------------------------------------------------------
module swa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_last,
    input  swa_pkg::swa_sts_t sts,
    output swa_pkg::swa_cmd_t cmd,
    output logic              out_load
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_EMIT  = 6'b001000,
        ST_TAKE  = 6'b010000,
        ST_FINAL = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;   // 0 pre-row flush, 1 end-of-input flush
    logic   mv_reg, mv_next;

    assign m_valid = mv_reg;
    assign s_ready = state_reg == ST_IDLE;
    assign m_last  = phase_reg ? 1'b1 : !sts.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                phase_next = 1'b0;
                if (sts.need_flush) state_next = ST_READ;
                else state_next = ST_TAKE;
            end
            ST_READ: begin
                if (!mv_reg || m_ready) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                out_load = 1'b1;
                mv_next  = 1'b1;
                cmd.emit = 1'b1;
                if (sts.emit_last) begin
                    cmd.end_group = 1'b1;
                    if (phase_reg) begin
                        state_next = ST_FINAL;
                    end else begin
                        cmd.part_clear = sts.part_change;
                        state_next     = ST_TAKE;
                    end
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_TAKE: begin
                cmd.take = 1'b1;
                if (sts.last) begin
                    phase_next = 1'b1;
                    state_next = ST_READ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL: begin
                cmd.stream_clear = 1'b1;
                state_next       = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// File: rtl/sql_window_aggregate_engine.sv
// ----------------------------------------------------------------------------
// sql_window_aggregate_engine
// Window aggregate over a sorted row stream.
// ----------------------------------------------------------------------------
// A row is accepted, classified, then folded in. When it closes a peer group,
// every buffered row of that group is emitted before the row is folded in,
// each result through a tag memory read and an output register load, the read
// waiting while a result still waits for the receiver; an end-of-stream row
// adds its own group flush and a stream clear.
module sql_window_aggregate_engine #(
    parameter int GROUP_DEPTH = 32,
    parameter int TAG_BITS    = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [2:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [63:0]        s_partition_key,
    input  logic [63:0]        s_order_key,
    input  logic signed [63:0] s_arg_value,
    input  logic               s_arg_is_null,
    input  logic [15:0]        s_row_tag,
    input  logic               s_stream_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_out_tag,
    output logic signed [63:0] m_agg_value,
    output logic               m_agg_is_null,
    output logic [1:0]         m_error_code,
    output logic               m_last_of_run
);
    logic [2:0] kind_reg;
    logic       star_reg;
    swa_pkg::swa_cmd_t cmd;
    swa_pkg::swa_sts_t sts;
    logic [15:0] res_tag;
    logic signed [63:0] res_value;
    logic res_null, out_load, last_c;
    logic [1:0] res_err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= swa_pkg::KIND_ROW_NUMBER;
            star_reg <= 1'b1;
        end else if (cfg_we) begin
            if (cfg_index == swa_pkg::CFG_AGG_KIND) kind_reg <= cfg_wdata;
            else star_reg <= cfg_wdata[0];
        end
    end

    swa_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .m_last(last_c), .sts, .cmd, .out_load
    );

    swa_datapath #(.GROUP_DEPTH(GROUP_DEPTH), .TAG_BITS(TAG_BITS)) u_dp (
        .aclk, .aresetn, .agg_kind(kind_reg), .count_star(star_reg),
        .s_partition_key, .s_order_key, .s_arg_value, .s_arg_is_null,
        .s_row_tag, .s_stream_end, .cmd, .sts,
        .res_tag, .res_value, .res_null, .res_err
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_tag     <= res_tag;
            m_agg_value   <= res_value;
            m_agg_is_null <= res_null;
            m_error_code  <= res_err;
            m_last_of_run <= last_c && sts.emit_last;
        end
    end
endmodule

// File: rtl/swa_checker.sv
// ----------------------------------------------------------------------------
// swa_checker
// Port-level checks of the window aggregate engine.
// ----------------------------------------------------------------------------
`include "sql_window_aggregate_engine_assert.svh"
module swa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_error_code,
    input logic        m_agg_is_null,
    input logic [63:0] m_agg_value
);
    `SWA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_agg_value))
    `SWA_ASSERT_IMPL(a_err, aclk, aresetn, m_valid, m_error_code != 2'd3)
    `SWA_ASSERT_IMPL(a_null, aclk, aresetn, m_valid && m_agg_is_null, m_agg_value == 64'd0)
    `SWA_ASSERT_NEXT(a_gap, aclk, aresetn, s_valid && s_ready, !s_ready)
endmodule

bind sql_window_aggregate_engine swa_checker u_swa_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_error_code, .m_agg_is_null, .m_agg_value
);
